>>> sv/pidfd_pkg.sv
// pidfd_pkg: shared types, constants and helpers for the filtered-derivative pid block
// no dependencies
`default_nettype none
package pidfd_pkg;
    localparam int unsigned SAMPLE_PERIOD_DEF = 655;
    localparam int unsigned SampleW = 17;

    localparam logic [31:0] KP_RST   = 32'sd65536;
    localparam logic [31:0] KI_RST   = 32'd0;
    localparam logic [31:0] KD_RST   = 32'd0;
    localparam logic [30:0] TAU_RST  = 31'd1310;
    localparam logic [31:0] IUL_RST  = 32'd327680;
    localparam logic [31:0] ILL_RST  = -32'sd327680;
    localparam logic [31:0] OUL_RST  = 32'd655360;
    localparam logic [31:0] OLL_RST  = -32'sd655360;

    typedef enum logic [2:0] {
        REG_KP  = 3'd0,
        REG_KI  = 3'd1,
        REG_KD  = 3'd2,
        REG_TAU = 3'd3,
        REG_IUL = 3'd4,
        REG_ILL = 3'd5,
        REG_OUL = 3'd6,
        REG_OLL = 3'd7
    } reg_idx_t;

    // sequencer phases
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_KIT,
        ST_MUL_INC,
        ST_INTEG,
        ST_MUL_D,
        ST_MUL_M,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } state_t;

    // operand select for the shared serial multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] mag_a;
        logic [63:0] mag_b;
        logic        neg;
        logic [4:0]  shift;
    } mul_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction
endpackage
`default_nettype wire

>>> sv/pidfd_mul.sv
// pidfd_mul: bit-serial shift-and-add multiplier with rounded right shift
// depends on pidfd_pkg
`default_nettype none
module pidfd_mul
    import pidfd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mul_req_t            req,
    output logic                     done,
    output logic signed [65:0]       result
);
    logic [63:0] acc_reg, acc_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic        neg_reg, neg_next;
    logic [4:0]  sh_reg, sh_next;
    logic        busy_reg, busy_next;
    logic [63:0] rnd;
    logic [63:0] q;

    // one multiplier bit per cycle; finishes when remaining bits are zero
    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        neg_next  = neg_reg;
        sh_next   = sh_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (req.start) begin
            acc_next  = '0;
            a_next    = req.mag_a;
            b_next    = req.mag_b;
            neg_next  = req.neg;
            sh_next   = req.shift;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end else begin
                if (b_reg[0])
                    acc_next = acc_reg + a_reg;
                a_next = {a_reg[62:0], 1'b0};
                b_next = {1'b0, b_reg[63:1]};
            end
        end
    end

    assign rnd    = 64'd1 << (sh_reg - 5'd1);
    assign q      = (acc_reg + rnd) >> sh_reg;
    assign result = neg_reg ? -$signed({2'b00, q}) : $signed({2'b00, q});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
        sh_reg  <= sh_next;
    end
endmodule
`default_nettype wire

>>> sv/pid_controller_filtered_derivative.sv
// pid_controller_filtered_derivative: top level, sequencer with serial multiply and divide
// depends on pidfd_pkg and pidfd_mul
//
// channel   dir   ports                                   handshake
// s_        in    s_setpoint, s_measurement               s_valid / s_ready
// m_        out   m_control_out                           m_valid / m_ready
// cfg       in    cfg_wr_en, cfg_index, cfg_wdata         write on enable
//
// an item passes from the input transfer to the output register through five serial
// multiplies, each stepping once per significant bit of the second operand, and a
// restoring divider of 64 quotient bits plus a rounding step.
// the output phase stalls while the previous result is still waiting on m_ready.
// reset returns the registers to their defaults and clears the filter state.
// the next item can be taken in the same cycle that the result sits in the output register.
`default_nettype none
module pid_controller_filtered_derivative
    import pidfd_pkg::*;
#(
    parameter int unsigned SAMPLE_PERIOD = SAMPLE_PERIOD_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_setpoint,
    input  wire logic signed [31:0] s_measurement,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_control_out,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata
);
    localparam logic [SampleW-1:0] TS = SampleW'(SAMPLE_PERIOD);

    logic signed [31:0] kp_reg, ki_reg, kd_reg, iul_reg, ill_reg, oul_reg, oll_reg;
    logic [30:0]        tau_reg;

    logic signed [31:0] last_err_reg, integ_reg, last_meas_reg, dterm_reg;
    logic signed [31:0] last_err_next, integ_next, last_meas_next, dterm_next;
    logic signed [31:0] sp_reg, sp_next, meas_reg, meas_next;
    logic signed [31:0] err_reg, err_next, prop_reg, prop_next, kit_reg, kit_next;
    logic signed [31:0] inc_reg, inc_next, dd_reg, dd_next;
    logic signed [31:0] deriv_reg, deriv_next;
    logic signed [31:0] out_reg, out_next;
    logic               out_vld_reg, out_vld_next;
    logic               issued_reg, issued_next;
    state_t             state_reg, state_next;

    // divider
    logic [63:0] dq_reg, dq_next;
    logic [33:0] drem_reg, drem_next;
    logic [6:0]  dcnt_reg, dcnt_next;
    logic        dneg_reg, dneg_next;
    logic [32:0] den;
    logic [33:0] dtrial;

    mul_req_t           mreq;
    logic               mdone;
    logic signed [65:0] mres;

    pidfd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .done    (mdone),
        .result  (mres)
    );

    function automatic logic [63:0] mag64(input logic signed [65:0] x);
        logic [65:0] u;
        u = x[65] ? 66'(-x) : 66'(x);
        return u[63:0];
    endfunction

    logic signed [65:0] w_a, w_b, lim_hi, lim_lo, integ_c, ysum, num;
    logic signed [31:0] integ_cl, y_cl;
    logic [63:0]        num_mag;

    assign den    = {1'b0, tau_reg, 1'b0} + 33'(TS);
    assign dtrial = {drem_reg[32:0], dq_reg[63]} - {1'b0, den};

    always_comb begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        meas_next      = meas_reg;
        err_next       = err_reg;
        prop_next      = prop_reg;
        kit_next       = kit_reg;
        inc_next       = inc_reg;
        dd_next        = dd_reg;
        deriv_next     = deriv_reg;
        last_err_next  = last_err_reg;
        integ_next     = integ_reg;
        last_meas_next = last_meas_reg;
        dterm_next     = dterm_reg;
        out_next       = out_reg;
        out_vld_next   = out_vld_reg;
        issued_next    = issued_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        dcnt_next      = dcnt_reg;
        dneg_next      = dneg_reg;
        mreq           = '0;
        w_a            = '0;
        w_b            = '0;
        lim_hi         = '0;
        lim_lo         = '0;
        integ_c        = '0;
        integ_cl       = '0;
        ysum           = '0;
        y_cl           = '0;
        num            = '0;
        num_mag        = '0;
        s_ready        = 1'b0;

        if (out_vld_reg && m_ready)
            out_vld_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sp_next    = s_setpoint;
                    meas_next  = s_measurement;
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_next    = sat32(66'(sp_reg) - 66'(meas_reg));
                issued_next = 1'b0;
                state_next  = ST_MUL_P;
            end
            ST_MUL_P, ST_MUL_KIT, ST_MUL_INC, ST_MUL_D, ST_MUL_M: begin
                case (state_reg)
                    ST_MUL_P: begin
                        w_a = 66'(kp_reg); w_b = 66'(err_reg); mreq.shift = 5'd16;
                    end
                    ST_MUL_KIT: begin
                        w_a = 66'(ki_reg); w_b = 66'(TS); mreq.shift = 5'd16;
                    end
                    ST_MUL_INC: begin
                        w_a = 66'(kit_reg); w_b = 66'(err_reg) + 66'(last_err_reg);
                        mreq.shift = 5'd17;
                    end
                    ST_MUL_D: begin
                        w_a = 66'(kd_reg); w_b = 66'(meas_reg) - 66'(last_meas_reg);
                        mreq.shift = 5'd15;
                    end
                    default: begin
                        w_a = 66'({tau_reg, 1'b0}) - 66'(TS); w_b = 66'(dterm_reg);
                        mreq.shift = 5'd16;
                    end
                endcase
                mreq.mag_a = mag64(w_a);
                mreq.mag_b = mag64(w_b);
                mreq.neg   = w_a[65] ^ w_b[65];
                if (!issued_reg) begin
                    mreq.start  = 1'b1;
                    issued_next = 1'b1;
                end else if (mdone) begin
                    issued_next = 1'b0;
                    case (state_reg)
                        ST_MUL_P: begin
                            prop_next = sat32(mres); state_next = ST_MUL_KIT;
                        end
                        ST_MUL_KIT: begin
                            kit_next = sat32(mres); state_next = ST_MUL_INC;
                        end
                        ST_MUL_INC: begin
                            inc_next = sat32(mres); state_next = ST_INTEG;
                        end
                        ST_MUL_D: begin
                            dd_next = sat32(mres); state_next = ST_MUL_M;
                        end
                        default: begin
                            state_next = ST_DIV;
                            num = 66'(sat32(mres)) - 66'(dd_reg);
                            num_mag   = mag64(num);
                            dq_next   = {num_mag[47:0], 16'd0};
                            dneg_next = num[65];
                            drem_next = '0;
                            dcnt_next = '0;
                        end
                    endcase
                end
            end
            ST_INTEG: begin
                integ_c  = 66'(sat32(66'(integ_reg) + 66'(inc_reg)));
                lim_hi   = (iul_reg > prop_reg) ? 66'(sat32(66'(iul_reg) - 66'(prop_reg))) : '0;
                lim_lo   = (ill_reg < prop_reg) ? 66'(sat32(66'(ill_reg) - 66'(prop_reg))) : '0;
                if (integ_c > lim_hi)
                    integ_cl = lim_hi[31:0];
                else if (integ_c < lim_lo)
                    integ_cl = lim_lo[31:0];
                else
                    integ_cl = integ_c[31:0];
                integ_next = integ_cl;
                state_next = ST_MUL_D;
            end
            ST_DIV: begin
                // restoring divide of (|num|<<16 + den/2) is done as rounding on remainder
                if (dcnt_reg == 7'd64) begin
                    // round: remainder*2 >= den rounds up (ties away)
                    if ({drem_reg, 1'b0} >= {2'b00, den})
                        dq_next = dq_reg + 64'd1;
                    state_next = ST_SUM;
                end else begin
                    if (!dtrial[33]) begin
                        drem_next = dtrial;
                        dq_next   = {dq_reg[62:0], 1'b1};
                    end else begin
                        drem_next = {drem_reg[32:0], dq_reg[63]};
                        dq_next   = {dq_reg[62:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg + 7'd1;
                end
            end
            ST_SUM: begin
                deriv_next = sat32(dneg_reg ? -$signed({2'b00, dq_reg}) : $signed({2'b00, dq_reg}));
                state_next = ST_OUT;
            end
            ST_OUT: begin
                ysum = 66'(sat32(66'(prop_reg) + 66'(integ_reg) + 66'(deriv_reg)));
                if (ysum > 66'(oul_reg))
                    y_cl = oul_reg;
                else if (ysum < 66'(oll_reg))
                    y_cl = oll_reg;
                else
                    y_cl = ysum[31:0];
                if (!out_vld_reg || m_ready) begin
                    out_next       = y_cl;
                    out_vld_next   = 1'b1;
                    dterm_next     = deriv_reg;
                    last_meas_next = meas_reg;
                    last_err_next  = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid       = out_vld_reg;
    assign m_control_out = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_vld_reg   <= 1'b0;
            issued_reg    <= 1'b0;
            last_err_reg  <= '0;
            integ_reg     <= '0;
            last_meas_reg <= '0;
            dterm_reg     <= '0;
            kp_reg  <= KP_RST;
            ki_reg  <= KI_RST;
            kd_reg  <= KD_RST;
            tau_reg <= TAU_RST;
            iul_reg <= IUL_RST;
            ill_reg <= ILL_RST;
            oul_reg <= OUL_RST;
            oll_reg <= OLL_RST;
        end else begin
            state_reg     <= state_next;
            out_vld_reg   <= out_vld_next;
            issued_reg    <= issued_next;
            last_err_reg  <= last_err_next;
            integ_reg     <= integ_next;
            last_meas_reg <= last_meas_next;
            dterm_reg     <= dterm_next;
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_KP:  kp_reg  <= cfg_wdata;
                    REG_KI:  ki_reg  <= cfg_wdata;
                    REG_KD:  kd_reg  <= cfg_wdata;
                    REG_TAU: tau_reg <= cfg_wdata[30:0];
                    REG_IUL: iul_reg <= cfg_wdata;
                    REG_ILL: ill_reg <= cfg_wdata;
                    REG_OUL: oul_reg <= cfg_wdata;
                    REG_OLL: oll_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        sp_reg    <= sp_next;
        meas_reg  <= meas_next;
        err_reg   <= err_next;
        prop_reg  <= prop_next;
        kit_reg   <= kit_next;
        inc_reg   <= inc_next;
        dd_reg    <= dd_next;
        deriv_reg <= deriv_next;
        out_reg   <= out_next;
        dq_reg    <= dq_next;
        drem_reg  <= drem_next;
        dcnt_reg  <= dcnt_next;
        dneg_reg  <= dneg_next;
    end
endmodule
`default_nettype wire
